[sv/tucv_pkg.sv]
// Shared types and constants for the TCP/UDP checksum verifier.
package tucv_pkg;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   localparam logic [15:0] PROTO_UDP   = 16'h0011;
   localparam logic [15:0] PROTO_TCP   = 16'h0006;
   localparam logic [15:0] UDP_MIN_LEN = 16'd8;
   localparam logic [15:0] TCP_MIN_LEN = 16'd20;
   localparam logic [14:0] UDP_CSUM_WORD = 15'd3;
   localparam logic [14:0] TCP_CSUM_WORD = 15'd8;

   typedef struct packed {
      logic        cmd;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic        is_udp;
      logic [15:0] seg_length;
      logic [7:0]  data_byte;
   } req_word_type;

   typedef struct packed {
      logic        checksum_ok;
      logic        malformed;
      logic [15:0] computed_sum;
      logic [15:0] received_sum;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic        malformed;
      logic [31:0] sum;
      logic [15:0] received_sum;
   } sum_stage_type;

endpackage

[sv/tcp_udp_checksum_verify.sv]
// Top level of the TCP/UDP checksum verifier with IPv4 pseudo header.
// The word that completes a segment is summed into the sum register when accepted; the
// fold and compare stage then loads the result register. Throughput: one word per cycle
// while req_stall is low; the running sum is updated in the cycle of acceptance.
// The sum register feeds a fold and compare stage, which feeds the output register.
// Synchronous active-high reset clears the segment state and empties both stages.
module tcp_udp_checksum_verify (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tucv_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tucv_pkg::rsp_word_type rsp_word
);

   tucv_pkg::sum_stage_type done;
   tucv_pkg::sum_stage_type sum_ff, sum_in;
   tucv_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;
   logic                    sum_advance;
   logic                    accept;
   logic [16:0]             fold_one;
   logic [15:0]             fold_two;
   logic [15:0]             complement;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign sum_advance = !sum_ff.valid || out_free;
   assign req_stall   = !sum_advance;
   assign accept      = req_valid && sum_advance;

   tucv_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .done     (done)
   );

   always_comb begin
      sum_in = sum_ff;
      if (sum_advance) begin
         sum_in = done;
      end
   end

   always_comb begin
      fold_one   = {1'b0, sum_ff.sum[15:0]} + {1'b0, sum_ff.sum[31:16]};
      fold_two   = fold_one[15:0] + {15'd0, fold_one[16]};
      complement = ~fold_two;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_free) begin
         rsp_valid_in = sum_ff.valid;
         if (sum_ff.malformed) begin
            rsp_word_in = '0;
            rsp_word_in.malformed = 1'b1;
         end else begin
            rsp_word_in.checksum_ok  = complement == sum_ff.received_sum;
            rsp_word_in.malformed    = 1'b0;
            rsp_word_in.computed_sum = complement;
            rsp_word_in.received_sum = sum_ff.received_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_word_ff  <= '0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_word_ff  <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.malformed) |->
      (!rsp_word.checksum_ok && rsp_word.computed_sum == 16'd0
       && rsp_word.received_sum == 16'd0))
      else $error("malformed result carries nonzero fields");

   a_ok_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.malformed) |->
      (rsp_word.checksum_ok == (rsp_word.computed_sum == rsp_word.received_sum)))
      else $error("checksum_ok disagrees with the compared sums");

   a_sum_held: assert property (@(posedge clock) disable iff (reset)
      (sum_ff.valid && rsp_valid && rsp_stall) |=> (sum_ff.valid && $stable(sum_ff)))
      else $error("pending sum lost while the output is stalled");

endmodule

[sv/tucv_accum.sv]
// Segment state and running ones' complement sum; flags the end of each segment.
module tucv_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  tucv_pkg::req_word_type req_word,
   output tucv_pkg::sum_stage_type done
);

   logic [31:0] accumulator_ff, accumulator_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] expected_length_ff, expected_length_in;
   logic [7:0]  pending_high_byte_ff, pending_high_byte_in;
   logic [15:0] captured_checksum_ff, captured_checksum_in;
   logic        udp_mode_ff, udp_mode_in;
   logic        busy_ff, busy_in;

   logic [31:0] header_sum;
   logic [15:0] min_length;
   logic        short_length;
   logic [14:0] csum_word;
   logic        last_byte;
   logic [15:0] pair_word;

   always_comb begin
      header_sum = {16'd0, req_word.src_addr[31:16]} + {16'd0, req_word.src_addr[15:0]}
                 + {16'd0, req_word.dst_addr[31:16]} + {16'd0, req_word.dst_addr[15:0]}
                 + {16'd0, (req_word.is_udp ? tucv_pkg::PROTO_UDP : tucv_pkg::PROTO_TCP)}
                 + {16'd0, req_word.seg_length};
      min_length   = req_word.is_udp ? tucv_pkg::UDP_MIN_LEN : tucv_pkg::TCP_MIN_LEN;
      short_length = req_word.seg_length < min_length;
      csum_word    = udp_mode_ff ? tucv_pkg::UDP_CSUM_WORD : tucv_pkg::TCP_CSUM_WORD;
      last_byte    = ({1'b0, byte_index_ff} + 17'd1) >= {1'b0, expected_length_ff};
      pair_word    = {pending_high_byte_ff, req_word.data_byte};
   end

   always_comb begin
      accumulator_in       = accumulator_ff;
      byte_index_in        = byte_index_ff;
      expected_length_in   = expected_length_ff;
      pending_high_byte_in = pending_high_byte_ff;
      captured_checksum_in = captured_checksum_ff;
      udp_mode_in          = udp_mode_ff;
      busy_in              = busy_ff;
      done                 = '0;
      if (accept) begin
         unique case (req_word.cmd)
            tucv_pkg::CMD_START: begin
               udp_mode_in          = req_word.is_udp;
               expected_length_in   = req_word.seg_length;
               byte_index_in        = '0;
               pending_high_byte_in = '0;
               captured_checksum_in = '0;
               accumulator_in       = header_sum;
               busy_in              = !short_length;
               done.valid           = short_length;
               done.malformed       = 1'b1;
            end
            tucv_pkg::CMD_BYTE: begin
               if (busy_ff) begin
                  if (!byte_index_ff[0]) begin
                     pending_high_byte_in = req_word.data_byte;
                     if (last_byte) begin
                        accumulator_in = accumulator_ff + {16'd0, req_word.data_byte, 8'd0};
                     end
                  end else if (byte_index_ff[15:1] == csum_word) begin
                     captured_checksum_in = pair_word;
                  end else begin
                     accumulator_in = accumulator_ff + {16'd0, pair_word};
                  end
                  byte_index_in = byte_index_ff + 16'd1;
                  if (last_byte) begin
                     busy_in      = 1'b0;
                     done.valid   = 1'b1;
                     done.malformed = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      done.sum          = accumulator_in;
      done.received_sum = captured_checksum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accumulator_ff       <= '0;
         byte_index_ff        <= '0;
         expected_length_ff   <= '0;
         pending_high_byte_ff <= '0;
         captured_checksum_ff <= '0;
         udp_mode_ff          <= 1'b0;
         busy_ff              <= 1'b0;
      end else begin
         accumulator_ff       <= accumulator_in;
         byte_index_ff        <= byte_index_in;
         expected_length_ff   <= expected_length_in;
         pending_high_byte_ff <= pending_high_byte_in;
         captured_checksum_ff <= captured_checksum_in;
         udp_mode_ff          <= udp_mode_in;
         busy_ff              <= busy_in;
      end
   end

endmodule
